[src/tcw_pkg.sv]
// ---------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

    localparam int OP_W      = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = CHAR_W + ATTR_W;

    localparam logic [CHAR_W-1:0] GLYPH_CURSOR = 8'd220;
    localparam logic [CHAR_W-1:0] GLYPH_BLANK  = 8'd32;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'd0;
    localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'd15;

    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_BACK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PUT_CH,
        ST_PUT_CUR,
        ST_NL_B1,
        ST_NL_B2,
        ST_LB,
        ST_SCR,
        ST_SCR_BLK,
        ST_LB_CUR,
        ST_BS,
        ST_BS_CUR,
        ST_CLR,
        ST_RD,
        ST_DONE
    } t_state;

endpackage

[src/tcw_req_if.sv]
// ---------------------------------------------------------------------------
// tcw_req_if
// Request channel: one console operation per transfer.
// ---------------------------------------------------------------------------
interface tcw_req_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output operation, output char_code,
                    output cell_index, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_index, output ready);
endinterface

[src/tcw_rsp_if.sv]
// ---------------------------------------------------------------------------
// tcw_rsp_if
// Result channel: cursor position and read cell contents.
// ---------------------------------------------------------------------------
interface tcw_rsp_if import tcw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [CHAR_W-1:0]    cell_glyph;
    logic [ATTR_W-1:0]    cell_attr;

    modport source (output valid, output cursor_row, output cursor_col,
                    output cell_glyph, output cell_attr, input ready);
    modport sink   (input valid, input cursor_row, input cursor_col,
                    input cell_glyph, input cell_attr, output ready);
endinterface

[src/tcw_cfg_if.sv]
// ---------------------------------------------------------------------------
// tcw_cfg_if
// Configuration write channel for the text color register.
// ---------------------------------------------------------------------------
interface tcw_cfg_if import tcw_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_color;

    modport source (output valid, output text_color, input ready);
    modport sink   (input valid, input text_color, output ready);
endinterface

[src/tcw_ram.sv]
// ---------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/text_console_writer_unit.sv]
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Character-cell console: cell store in RAM, cursor tracking, scroll/clear.
// ---------------------------------------------------------------------------
// channel  | dir | transfer                 | payload
// i_req    | in  | valid & ready            | operation, char_code, cell_index
// o_rsp    | out | valid & ready            | cursor_row, cursor_col, glyph, attr
// i_cfg    | in  | valid & ready (ready=1)  | text_color
//
// A scroll adds a RAM copy walk, one cell a cycle on the single write port.
// Reset: a clearing pass zeroes the store; no request is taken until it ends.
// A stalled result holds the next request at its last step until taken.
// ---------------------------------------------------------------------------
module text_console_writer_unit import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcw_req_if.sink    i_req,
    tcw_rsp_if.source  o_rsp,
    tcw_cfg_if.sink    i_cfg
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int MAW   = $clog2(CELLS);
    localparam int AW    = $clog2(CELLS + COLUMNS + 2);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] CELLS_A   = AW'(CELLS);
    localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] COLS_C    = CW'(COLUMNS);

    t_state              r_state, n_state;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic [AW-1:0]       r_base, n_base;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic                r_cp_vld, n_cp_vld;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic [ATTR_W-1:0]   r_color;
    logic [CELL_W-1:0]   r_cell, n_cell;

    logic                 r_out_valid, n_out_valid;
    logic [ROW_OUT_W-1:0] r_out_row, n_out_row;
    logic [COL_OUT_W-1:0] r_out_col, n_out_col;
    logic [CELL_W-1:0]    r_out_cell, n_out_cell;

    logic [AW-1:0]       here, here_p1, here_m1;
    logic                w_en;
    logic [AW-1:0]       w_addr;
    logic [CELL_W-1:0]   w_data;
    logic [MAW-1:0]      rd_addr;
    logic [CELL_W-1:0]   rd_data;
    logic                fin;
    logic [CELL_W-1:0]   fin_cell;
    logic                slot_free;
    logic                req_ready;
    logic                idx_ok;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_en && (w_addr < CELLS_A)),
        .i_waddr (w_addr[MAW-1:0]),
        .i_wdata (w_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign here      = r_base + AW'(r_col);
    assign here_p1   = here + AW'(1);
    assign here_m1   = here - AW'(1);
    assign slot_free = !r_out_valid || o_rsp.ready;
    assign idx_ok    = 32'(i_req.cell_index) < 32'(CELLS);

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_base     = r_base;
        n_ptr      = r_ptr;
        n_cp_vld   = r_cp_vld;
        n_char     = r_char;
        n_cell     = r_cell;
        w_en       = 1'b0;
        w_addr     = here;
        w_data     = {r_color, GLYPH_BLANK};
        rd_addr    = r_ptr[MAW-1:0];
        fin        = 1'b0;
        fin_cell   = r_cell;
        req_ready  = 1'b0;

        unique case (r_state)
            ST_INIT: begin
                w_en   = 1'b1;
                w_addr = r_ptr;
                w_data = '0;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == CELLS_A - AW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                req_ready = 1'b1;
                if (i_req.valid) begin
                    n_char = i_req.char_code;
                    n_cell = '0;
                    unique case (t_op'(i_req.operation))
                        OP_PUT: begin
                            if (i_req.char_code == CHAR_NUL) begin
                                n_state = ST_DONE;
                            end else if (i_req.char_code == CHAR_NEWLINE) begin
                                n_state = ST_NL_B1;
                            end else if (r_col < COLS_C) begin
                                w_en    = 1'b1;
                                w_data  = {r_color, i_req.char_code};
                                n_state = ST_PUT_CUR;
                            end else begin
                                n_state = ST_LB;
                            end
                        end
                        OP_BACK: begin
                            n_state = (r_col == '0) ? ST_DONE : ST_BS;
                        end
                        OP_CLEAR: begin
                            n_ptr   = '0;
                            n_state = ST_CLR;
                        end
                        OP_READ: begin
                            rd_addr = MAW'(i_req.cell_index);
                            n_state = idx_ok ? ST_RD : ST_DONE;
                        end
                    endcase
                end
            end
            ST_PUT_CH: begin
                w_en    = 1'b1;
                w_data  = {r_color, r_char};
                n_state = ST_PUT_CUR;
            end
            ST_PUT_CUR: begin
                w_en   = 1'b1;
                w_addr = here_p1;
                w_data = {r_color, GLYPH_CURSOR};
                n_col  = r_col + CW'(1);
                fin    = 1'b1;
            end
            ST_NL_B1: begin
                w_en    = 1'b1;
                n_state = ST_NL_B2;
            end
            ST_NL_B2: begin
                w_en    = 1'b1;
                w_addr  = here_p1;
                n_state = ST_LB;
            end
            ST_LB: begin
                n_col = '0;
                if (r_row < LAST_ROW) begin
                    n_row   = r_row + RW'(1);
                    n_base  = r_base + COLS_A;
                    n_state = (r_char == CHAR_NEWLINE) ? ST_LB_CUR : ST_PUT_CH;
                end else begin
                    n_ptr    = COLS_A;
                    n_cp_vld = 1'b0;
                    n_state  = ST_SCR;
                end
            end
            ST_SCR: begin
                // read cell i, write it one row up in the following cycle
                w_en     = r_cp_vld;
                w_addr   = r_ptr - COLS_A - AW'(1);
                w_data   = rd_data;
                n_cp_vld = r_ptr < CELLS_A;
                n_ptr    = r_ptr + AW'(1);
                if (r_ptr == CELLS_A) begin
                    n_ptr   = LAST_BASE;
                    n_state = ST_SCR_BLK;
                end
            end
            ST_SCR_BLK: begin
                w_en   = 1'b1;
                w_addr = r_ptr;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == CELLS_A - AW'(1)) begin
                    n_state = (r_char == CHAR_NEWLINE) ? ST_LB_CUR : ST_PUT_CH;
                end
            end
            ST_LB_CUR: begin
                w_en   = 1'b1;
                w_addr = r_base;
                w_data = {r_color, GLYPH_CURSOR};
                fin    = 1'b1;
            end
            ST_BS: begin
                w_en    = 1'b1;
                w_addr  = here_m1;
                n_col   = r_col - CW'(1);
                n_state = ST_BS_CUR;
            end
            ST_BS_CUR: begin
                w_en   = 1'b1;
                w_addr = here_p1;
                w_data = {r_color, GLYPH_CURSOR};
                fin    = 1'b1;
            end
            ST_CLR: begin
                w_en   = 1'b1;
                w_addr = r_ptr;
                n_ptr  = r_ptr + AW'(1);
                if (r_ptr == CELLS_A - AW'(1)) begin
                    n_row  = '0;
                    n_col  = '0;
                    n_base = '0;
                    fin    = 1'b1;
                end
            end
            ST_RD: begin
                n_cell   = rd_data;
                fin_cell = rd_data;
                fin      = 1'b1;
            end
            ST_DONE: begin
                fin = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (fin) begin
            n_state = slot_free ? ST_IDLE : ST_DONE;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_cell  = r_out_cell;
        if (fin && slot_free) begin
            n_out_valid = 1'b1;
            n_out_row   = ROW_OUT_W'(n_row);
            n_out_col   = COL_OUT_W'(n_col);
            n_out_cell  = fin_cell;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_row       <= '0;
            r_col       <= '0;
            r_base      <= '0;
            r_ptr       <= '0;
            r_cp_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_color     <= COLOR_RESET;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_base      <= n_base;
            r_ptr       <= n_ptr;
            r_cp_vld    <= n_cp_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_color <= i_cfg.text_color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_cell     <= n_cell;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_cell <= n_out_cell;
    end

    assign i_req.ready      = req_ready;
    assign i_cfg.ready      = 1'b1;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cursor_row = r_out_row;
    assign o_rsp.cursor_col = r_out_col;
    assign o_rsp.cell_glyph = r_out_cell[CHAR_W-1:0];
    assign o_rsp.cell_attr  = r_out_cell[CELL_W-1:CHAR_W];
endmodule
